/* hw/rtl/frame_bitmap_allocator_defines.svh */
// ---------------------------------------------------------------------------
// Frame bitmap allocator assertion macros
// Shared property forms for the assertion checkers of the frame allocator.
// ---------------------------------------------------------------------------
`ifndef FRAME_BITMAP_ALLOCATOR_DEFINES_SVH
`define FRAME_BITMAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FBA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/fba_pkg.sv */
// ---------------------------------------------------------------------------
// Frame bitmap allocator package
// Command and status codes, payload structs and default sizes.
// ---------------------------------------------------------------------------
package fba_pkg;

	// Width of a frame number on the request and response channels.
	localparam int unsigned FRAME_W = 12;
	localparam int unsigned FLAGS_W = 3;

	// Frames that a frame number field can name.
	localparam int unsigned FIELD_FRAMES = 32'h1000;

	// Default sizing of the bitmap.
	localparam int unsigned FRAME_COUNT_DEF = 4096;
	localparam int unsigned WORD_BITS_DEF   = 8 * 4;

	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_TEST  = 2'd2,
		CMD_MARK  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_MAPPED    = 2'd1,
		ST_NO_FREE   = 2'd2,
		ST_ZERO_FREE = 2'd3
	} status_t;

	// Page flag bit positions.
	localparam int unsigned FLAG_PRESENT  = 0;
	localparam int unsigned FLAG_WRITABLE = 1;
	localparam int unsigned FLAG_USER     = 2;

	typedef struct packed {
		cmd_t               cmd;
		logic [FRAME_W-1:0] frame;
		logic               kernel_mode;
		logic               writable;
	} req_t;

	typedef struct packed {
		logic [FRAME_W-1:0] result_frame;
		logic [FLAGS_W-1:0] page_flags;
		logic               frame_used;
		status_t            status;
	} rsp_t;

endpackage

/* hw/rtl/frame_bitmap_allocator.sv */
// Request path: a request transfer loads stage 1 and reads the bitmap word;
// stage 1 loads the response register, which drives rsp_valid, once that is free or draining.
// One request in flight: the next is taken only after stage 1 hands over, since the
// bitmap word memory is read on transfer and written back as stage 1 hands over.
// Reset: a clearing pass zeroes one bitmap word per cycle, ceil(min(FRAME_COUNT,
// 4096) / WORD_BITS) words (128 with the defaults), with req_stall held high.
// ---------------------------------------------------------------------------
// Frame bitmap allocator
// First-fit page frame allocator over a used-frame bitmap in word memory.
// ---------------------------------------------------------------------------
module frame_bitmap_allocator #(
	parameter int unsigned FRAME_COUNT = fba_pkg::FRAME_COUNT_DEF,
	parameter int unsigned WORD_BITS   = fba_pkg::WORD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  fba_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output fba_pkg::rsp_t rsp
);

	import fba_pkg::*;

	// Only frames that a frame number can name are ever kept.
	localparam int unsigned LIMIT     = (FRAME_COUNT < FIELD_FRAMES) ? FRAME_COUNT
		: FIELD_FRAMES;
	localparam int unsigned NWORDS    = (LIMIT + WORD_BITS - 1) / WORD_BITS;
	localparam int unsigned WADDR_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int unsigned BIT_W     = $clog2(WORD_BITS);
	localparam int unsigned LAST_BITS = LIMIT - (NWORDS - 1) * WORD_BITS;
	localparam int unsigned LIM_W     = FRAME_W + 1;
	localparam logic [WORD_BITS-1:0] LAST_MASK = {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_BITS);
	localparam logic [WORD_BITS-1:0] ONE_BIT   = {{(WORD_BITS - 1){1'b0}}, 1'b1};

	// Word index of a frame by multiplying with a rounded-up reciprocal.
	localparam int unsigned RECIP_SH = 24;
	localparam int unsigned RECIP    = ((1 << RECIP_SH) + WORD_BITS - 1) / WORD_BITS;
	localparam int unsigned RECIP_W  = $clog2(RECIP + 1);
	localparam int unsigned PROD_W   = FRAME_W + RECIP_W;

	logic                 acc;
	logic                 in_rng;
	logic                 search;
	logic [PROD_W-1:0]    prod;
	logic [WADDR_W-1:0]   qword;
	logic [WADDR_W-1:0]   free_idx;
	logic                 free_hit;

	logic                 clearing_q;
	logic [WADDR_W-1:0]   clr_q;

	logic                 busy_s1;
	cmd_t                 cmd_s1;
	logic [FRAME_W-1:0]   frame_s1;
	logic                 kern_s1;
	logic                 wr_s1;
	logic [WADDR_W-1:0]   widx_s1;
	logic                 hit_s1;
	logic                 rng_s1;

	logic [WORD_BITS-1:0] word;
	logic [WORD_BITS-1:0] mask;
	logic [WORD_BITS-1:0] blocked;
	logic [FRAME_W-1:0]   base;
	logic [FRAME_W-1:0]   bit_diff;
	logic [BIT_W-1:0]     bit_s1;
	logic [BIT_W-1:0]     lz;
	logic                 advance;
	logic                 upd_en;
	logic [WORD_BITS-1:0] upd_word;
	logic                 upd_full;
	rsp_t                 nxt_rsp;

	logic                 mem_wr_en;
	logic [WADDR_W-1:0]   mem_wr_addr;
	logic [WORD_BITS-1:0] mem_wr_data;
	logic [WADDR_W-1:0]   mem_rd_addr;

	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	// Request side: one request in flight, none during the clearing pass.
	assign req_stall = busy_s1 | clearing_q;
	assign acc       = req_valid & ~req_stall;
	assign in_rng    = {1'b0, req.frame} < LIM_W'(LIMIT);
	assign search    = (req.cmd == CMD_ALLOC) && (req.frame == '0);
	assign prod      = PROD_W'(req.frame) * PROD_W'(RECIP);
	assign qword     = prod[RECIP_SH +: WADDR_W];
	assign mem_rd_addr = search ? free_idx : qword;

	fba_search #(
		.NWORDS  (NWORDS),
		.WADDR_W (WADDR_W)
	) u_search (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd_en   (upd_en),
		.upd_idx  (widx_s1),
		.upd_full (upd_full),
		.free_idx (free_idx),
		.free_hit (free_hit)
	);

	// Memory write port is shared by the clearing pass and write-back.
	assign mem_wr_en   = clearing_q | upd_en;
	assign mem_wr_addr = clearing_q ? clr_q : widx_s1;
	assign mem_wr_data = clearing_q ? '0 : upd_word;

	fba_ram #(
		.DEPTH  (NWORDS),
		.WIDTH  (WORD_BITS),
		.ADDR_W (WADDR_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (acc),
		.rd_addr (mem_rd_addr),
		.rd_data (word)
	);

	// Clearing pass after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			if (clr_q == WADDR_W'(NWORDS - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_q <= clr_q + 1'b1;
		end
	end

	// Stage 1 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else if (acc) begin
			busy_s1 <= 1'b1;
		end else if (advance) begin
			busy_s1 <= 1'b0;
		end
	end

	// Stage 1 payload, captured on the request transfer.
	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_s1   <= req.cmd;
			frame_s1 <= req.frame;
			kern_s1  <= req.kernel_mode;
			wr_s1    <= req.writable;
			widx_s1  <= mem_rd_addr;
			hit_s1   <= free_hit;
			rng_s1   <= in_rng;
		end
	end

	// Bit position inside the word and the valid-bit mask of the last word.
	assign base     = FRAME_W'(widx_s1 * WORD_BITS);
	assign bit_diff = frame_s1 - base;
	assign bit_s1   = bit_diff[BIT_W-1:0];
	assign mask     = (widx_s1 == WADDR_W'(NWORDS - 1)) ? LAST_MASK : '1;
	assign blocked  = word | ~mask;

	// Lowest clear bit of the word for allocation.
	always_comb begin
		lz = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!blocked[i]) begin
				lz = BIT_W'(i);
			end
		end
	end

	// Command decode and the modified word.
	always_comb begin
		upd_en   = 1'b0;
		upd_word = word;
		nxt_rsp  = '{result_frame: '0, page_flags: '0, frame_used: 1'b0, status: ST_OK};
		unique case (cmd_s1)
			CMD_ALLOC: begin
				if (frame_s1 != '0) begin
					nxt_rsp.result_frame = frame_s1;
					nxt_rsp.status       = ST_MAPPED;
				end else if (!hit_s1) begin
					nxt_rsp.status = ST_NO_FREE;
				end else begin
					upd_en   = 1'b1;
					upd_word = word | (ONE_BIT << lz);
					nxt_rsp.result_frame = base + FRAME_W'(lz);
					nxt_rsp.page_flags[FLAG_PRESENT]  = 1'b1;
					nxt_rsp.page_flags[FLAG_WRITABLE] = wr_s1;
					nxt_rsp.page_flags[FLAG_USER]     = ~kern_s1;
				end
			end
			CMD_FREE: begin
				if (frame_s1 == '0) begin
					nxt_rsp.status = ST_ZERO_FREE;
				end else begin
					upd_en   = rng_s1;
					upd_word = word & ~(ONE_BIT << bit_s1);
				end
			end
			CMD_TEST: begin
				nxt_rsp.result_frame = frame_s1;
				nxt_rsp.frame_used   = rng_s1 & word[bit_s1];
			end
			CMD_MARK: begin
				nxt_rsp.result_frame = frame_s1;
				upd_en   = rng_s1;
				upd_word = word | (ONE_BIT << bit_s1);
			end
			default: begin
				upd_en = 1'b0;
			end
		endcase
		upd_en = upd_en & advance;
	end

	assign upd_full = &(upd_word | ~mask);

	// Stage 1 hands over once the response register is free or draining.
	assign advance = busy_s1 & (~rsp_valid_q | ~rsp_stall);

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= nxt_rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* hw/rtl/fba_ram.sv */
// ---------------------------------------------------------------------------
// Frame bitmap allocator word memory
// Simple dual-port synchronous memory with registered read.
// ---------------------------------------------------------------------------
module fba_ram #(
	parameter int unsigned DEPTH  = 128,
	parameter int unsigned WIDTH  = 32,
	parameter int unsigned ADDR_W = 7
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port; data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* hw/rtl/fba_search.sv */
// ---------------------------------------------------------------------------
// Frame bitmap allocator free word search
// Keeps one full flag per bitmap word and finds the lowest word with room.
// ---------------------------------------------------------------------------
module fba_search #(
	parameter int unsigned NWORDS  = 128,
	parameter int unsigned WADDR_W = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               upd_en,
	input  logic [WADDR_W-1:0] upd_idx,
	input  logic               upd_full,
	output logic [WADDR_W-1:0] free_idx,
	output logic               free_hit
);

	logic [NWORDS-1:0] full_q;

	// The bitmap is all clear after reset, so no word is full.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= '0;
		end else if (upd_en) begin
			full_q[upd_idx] <= upd_full;
		end
	end

	// Priority encoder: lowest word that still has a clear bit.
	always_comb begin
		free_idx = '0;
		free_hit = 1'b0;
		for (int i = NWORDS - 1; i >= 0; i--) begin
			if (!full_q[i]) begin
				free_idx = WADDR_W'(i);
				free_hit = 1'b1;
			end
		end
	end

endmodule

/* hw/rtl/fba_checker.sv */
// ---------------------------------------------------------------------------
// Frame bitmap allocator port checker
// Checks response consistency and request pacing seen at the top-level ports.
// ---------------------------------------------------------------------------
`include "frame_bitmap_allocator_defines.svh"

module fba_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input fba_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input fba_pkg::rsp_t rsp
);

	import fba_pkg::*;

	// Flags are only handed out with a successful allocation.
	`FBA_ASSERT_IMPLY(a_flags_ok, clk, arst_n, rsp_valid && (rsp.page_flags != '0), (rsp.page_flags[FLAG_PRESENT] == 1'b1) && (rsp.status == ST_OK), "page flags without successful allocation")

	// A used report comes only with a good status and no flags.
	`FBA_ASSERT_IMPLY(a_used_ok, clk, arst_n, rsp_valid && rsp.frame_used, (rsp.status == ST_OK) && (rsp.page_flags == '0), "frame used reported with bad status or flags")

	// A request transfer is followed by stall while it is worked on.
	`FBA_ASSERT_NEXT(a_one_in_flight, clk, arst_n, req_valid && !req_stall, req_stall, "second request taken while one is in flight")

	// A stalled response holds.
	`FBA_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled response changed")

endmodule

bind frame_bitmap_allocator fba_checker u_fba_checker (.*);

/* bench/frame_bitmap_allocator_tb.sv */
// ---------------------------------------------------------------------------
// Frame bitmap allocator testbench
// Drives alloc, free, test and mark requests through the valid/stall request
// channel and checks every response, field by field and in order, against an
// in-bench model of the used-frame bitmap. A directed opening covers the flag
// combinations and the special cases, random traffic follows, and a closing
// phase frees frames and reallocates them so the lowest free frames are reused.
// ---------------------------------------------------------------------------
module frame_bitmap_allocator_tb;
	import fba_pkg::*;

	localparam int unsigned FRAMES      = FRAME_COUNT_DEF;
	localparam int unsigned SEARCH_END  = (FRAMES < FIELD_FRAMES) ? FRAMES : FIELD_FRAMES;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned MAX_REPORTS = 10;

	logic  clk       = 1'b0;
	logic  arst_n    = 1'b0;
	logic  req_valid = 1'b0;
	logic  req_stall;
	req_t  req       = '0;
	logic  rsp_valid;
	logic  rsp_stall = 1'b0;
	rsp_t  rsp;

	// Model of the used-frame bitmap, updated at each request transfer.
	bit    frame_map [FRAMES];

	req_t  req_backlog [$];
	rsp_t  owed_rsps [$];
	int unsigned cycle_count = 0;
	int unsigned mismatches  = 0;

	frame_bitmap_allocator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #6 clk = ~clk;

	// Reset is held at the start of the run only.
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Lowest clear frame below the search limit, or -1 when all are used.
	function automatic int lowest_free_frame();
		for (int f = 0; f < SEARCH_END; f++) begin
			if (!frame_map[f]) return f;
		end
		return -1;
	endfunction

	// A nonzero frame that is currently marked used, or a random one if none.
	function automatic logic [FRAME_W-1:0] pick_used_frame();
		int start;
		int f;
		start = $urandom_range(FRAMES - 1);
		for (int k = 0; k < FRAMES; k++) begin
			f = (start + k) % FRAMES;
			if (f != 0 && frame_map[f]) return FRAME_W'(f);
		end
		return FRAME_W'($urandom_range(FIELD_FRAMES - 1));
	endfunction

	// Applies one request to the bitmap model and returns its response.
	function automatic rsp_t serve_request(req_t r);
		rsp_t o;
		int   slot;
		o = '0;
		o.status = ST_OK;
		case (r.cmd)
			CMD_ALLOC: begin
				if (r.frame != 0) begin
					o.result_frame = r.frame;
					o.status = ST_MAPPED;
				end else begin
					slot = lowest_free_frame();
					if (slot < 0) begin
						o.status = ST_NO_FREE;
					end else begin
						frame_map[slot] = 1'b1;
						o.result_frame = FRAME_W'(slot);
						o.page_flags[FLAG_PRESENT]  = 1'b1;
						o.page_flags[FLAG_WRITABLE] = r.writable;
						o.page_flags[FLAG_USER]     = ~r.kernel_mode;
					end
				end
			end
			CMD_FREE: begin
				if (r.frame == 0) begin
					o.status = ST_ZERO_FREE;
				end else if (r.frame < FRAMES) begin
					frame_map[r.frame] = 1'b0;
				end
			end
			CMD_TEST: begin
				o.result_frame = r.frame;
				o.frame_used = (r.frame < FRAMES) && frame_map[r.frame];
			end
			default: begin
				o.result_frame = r.frame;
				if (r.frame < FRAMES) frame_map[r.frame] = 1'b1;
			end
		endcase
		return o;
	endfunction

	// Random pause of either side, with a stretch of full-rate traffic.
	function automatic bit take_pause();
		if (cycle_count >= 800 && cycle_count < 1600) return 1'b0;
		return $urandom_range(99) < 8;
	endfunction

	// Queues one request, keeping the backlog short so that picks of used
	// frames follow the bitmap closely.
	task automatic post_request(input cmd_t c, input logic [FRAME_W-1:0] f,
			input logic km, input logic wr);
		req_t r;
		r.cmd         = c;
		r.frame       = f;
		r.kernel_mode = km;
		r.writable    = wr;
		while (req_backlog.size() >= 4) @(posedge clk);
		req_backlog.push_back(r);
	endtask

	// Request driver: predicts each transfer and loads the next request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
		end else if (!req_valid || !req_stall) begin
			if (req_valid) owed_rsps.push_back(serve_request(req));
			if (req_backlog.size() != 0 && !take_pause()) begin
				req_valid <= 1'b1;
				req       <= req_backlog.pop_front();
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Response monitor: checks each transfer against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid === 1'b1 && !rsp_stall) begin
				if (owed_rsps.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected response: frame %0d flags %0d used %0d status %0d",
							rsp.result_frame, rsp.page_flags, rsp.frame_used, rsp.status);
				end else begin
					want = owed_rsps.pop_front();
					if (rsp.result_frame !== want.result_frame ||
						rsp.page_flags !== want.page_flags ||
						rsp.frame_used !== want.frame_used ||
						rsp.status !== want.status) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("response mismatch: expected frame %0d flags %0d",
								want.result_frame, want.page_flags,
								" used %0d status %0d,", want.frame_used, want.status,
								" got frame %0d flags %0d", rsp.result_frame,
								rsp.page_flags, " used %0d status %0d",
								rsp.frame_used, rsp.status);
					end
				end
			end
			rsp_stall <= take_pause();
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("frame_bitmap_allocator_tb failed");
			$finish;
		end
	end

	// Stimulus and end of run.
	initial begin
		int   n;
		int   roll;
		int   word;
		logic [FRAME_W-1:0] f;

		// Directed: all flag combinations, mapped entries, zero frees, extremes.
		post_request(CMD_TEST, 0, 1'b0, 1'b0);
		post_request(CMD_ALLOC, 0, 1'b0, 1'b0);
		post_request(CMD_ALLOC, 0, 1'b1, 1'b1);
		post_request(CMD_ALLOC, 0, 1'b0, 1'b1);
		post_request(CMD_ALLOC, 0, 1'b1, 1'b0);
		post_request(CMD_ALLOC, 12'hFFF, 1'b1, 1'b1);
		post_request(CMD_ALLOC, 1, 1'b0, 1'b0);
		post_request(CMD_FREE, 0, 1'b1, 1'b1);
		post_request(CMD_FREE, 2, 1'b0, 1'b0);
		post_request(CMD_TEST, 2, 1'b0, 1'b0);
		post_request(CMD_TEST, 1, 1'b1, 1'b1);
		post_request(CMD_ALLOC, 0, 1'b0, 1'b1);
		post_request(CMD_MARK, 12'hFFF, 1'b0, 1'b0);
		post_request(CMD_TEST, 12'hFFF, 1'b0, 1'b0);
		post_request(CMD_FREE, 12'hFFF, 1'b1, 1'b1);
		post_request(CMD_TEST, 12'hFFF, 1'b1, 1'b0);
		post_request(CMD_MARK, 12'h800, 1'b1, 1'b1);
		post_request(CMD_TEST, 12'h7FF, 1'b0, 1'b1);
		post_request(CMD_TEST, 12'h800, 1'b0, 1'b1);
		post_request(CMD_FREE, 12'h555, 1'b0, 1'b0);
		post_request(CMD_MARK, 4, 1'b0, 1'b0);
		post_request(CMD_ALLOC, 0, 1'b1, 1'b1);

		// Random traffic: allocations, frees of held and random frames, tests and marks.
		n = 0;
		while (n < 760) begin
			roll = $urandom_range(99);
			if (roll < 35) begin
				post_request(CMD_ALLOC, 0, 1'($urandom_range(1)), 1'($urandom_range(1)));
			end else if (roll < 40) begin
				post_request(CMD_ALLOC, FRAME_W'($urandom_range(FIELD_FRAMES - 1)),
					1'($urandom_range(1)), 1'($urandom_range(1)));
			end else if (roll < 60) begin
				post_request(CMD_FREE, pick_used_frame(), 1'($urandom_range(1)),
					1'($urandom_range(1)));
			end else if (roll < 65) begin
				post_request(CMD_FREE, FRAME_W'($urandom_range(FIELD_FRAMES - 1)),
					1'($urandom_range(1)), 1'($urandom_range(1)));
			end else if (roll < 68) begin
				post_request(CMD_FREE, 0, 1'($urandom_range(1)), 1'($urandom_range(1)));
			end else if (roll < 80) begin
				post_request(CMD_TEST, pick_used_frame(), 1'($urandom_range(1)),
					1'($urandom_range(1)));
			end else if (roll < 90) begin
				post_request(CMD_TEST, FRAME_W'($urandom_range(FIELD_FRAMES - 1)),
					1'($urandom_range(1)), 1'($urandom_range(1)));
			end else if (roll < 95) begin
				post_request(CMD_MARK, FRAME_W'($urandom_range(FIELD_FRAMES - 1)),
					1'($urandom_range(1)), 1'($urandom_range(1)));
			end else begin
				// Fill a whole word just ahead of the allocation front so the
				// search has full words to skip.
				word = lowest_free_frame() / 32 + $urandom_range(1, 3);
				if (word * 32 + 31 < FRAMES) begin
					for (int b = 0; b < 32; b++)
						post_request(CMD_MARK, FRAME_W'(word * 32 + b), 1'($urandom_range(1)),
							1'($urandom_range(1)));
					n += 31;
				end
			end
			n++;
		end

		// Free a few frames and take them back through the first-fit search.
		for (int i = 0; i < 30; i++) begin
			f = FRAME_W'($urandom_range(1, FIELD_FRAMES - 1));
			post_request(CMD_FREE, f, 1'($urandom_range(1)), 1'($urandom_range(1)));
			if ($urandom_range(1)) begin
				post_request(CMD_FREE, FRAME_W'($urandom_range(1, FIELD_FRAMES - 1)),
					1'($urandom_range(1)), 1'($urandom_range(1)));
				post_request(CMD_TEST, f, 1'($urandom_range(1)), 1'($urandom_range(1)));
				post_request(CMD_ALLOC, 0, 1'($urandom_range(1)), 1'($urandom_range(1)));
			end
			post_request(CMD_ALLOC, 0, 1'($urandom_range(1)), 1'($urandom_range(1)));
			post_request(CMD_ALLOC, 0, 1'($urandom_range(1)), 1'($urandom_range(1)));
			post_request(CMD_TEST, f, 1'($urandom_range(1)), 1'($urandom_range(1)));
		end

		// Drain: all requests accepted, all responses in, then a short tail.
		// Sampling on the falling edge sees the driver's settled state.
		while (req_backlog.size() != 0 || req_valid) @(negedge clk);
		while (owed_rsps.size() != 0) @(negedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && owed_rsps.size() == 0) begin
			$display("frame_bitmap_allocator_tb passed");
		end else begin
			$display("frame_bitmap_allocator_tb failed");
		end
		$finish;
	end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/fba_pkg.sv
hw/rtl/fba_ram.sv
hw/rtl/fba_search.sv
hw/rtl/frame_bitmap_allocator.sv
hw/rtl/fba_checker.sv
bench/frame_bitmap_allocator_tb.sv
